@@ hdl/assert_macros.svh @@
// Assertion shorthands for the ray/triangle intersection block.
// Used by the queue and back-end modules; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RTI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define RTI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rti_pkg.sv @@
// Shared types and constants for the ray/triangle intersection block.
// No dependencies; imported by every module of the block.
`default_nettype none

package rti_pkg;

  localparam int VEC_W     = 63;
  localparam int EPS_W     = 20;
  localparam int EPS_RESET = 10737;
  localparam int DIST_W    = 32;
  localparam int DIST_FRAC = 16;
  // quotient bits kept before saturation: one more than the distance width
  localparam int QUOT_W    = DIST_W + 1;
  localparam int QDEPTH    = 4;

  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_DET_EPS = reg_idx_t'(0);

  typedef logic [2:0] outcome_t;
  localparam outcome_t OUT_HIT      = 3'd0;
  localparam outcome_t OUT_PARALLEL = 3'd1;
  localparam outcome_t OUT_U_RANGE  = 3'd2;
  localparam outcome_t OUT_V_RANGE  = 3'd3;
  localparam outcome_t OUT_BEHIND   = 3'd4;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

@@ hdl/rti_front.sv @@
// Front end: edges, cross products, determinant and barycentric range tests.
// Depends on rti_pkg; feeds classified items into rti_queue.
`default_nettype none

module rti_front import rti_pkg::*; #(
  parameter int COORD_WIDTH = 21
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [VEC_W-1:0]      in_ray_origin,
  input  wire logic [VEC_W-1:0]      in_ray_direction,
  input  wire logic [VEC_W-1:0]      in_vertex_a,
  input  wire logic [VEC_W-1:0]      in_vertex_b,
  input  wire logic [VEC_W-1:0]      in_vertex_c,
  input  wire logic [EPS_W-1:0]      det_eps,
  input  wire logic                  q_full,
  output logic                       push,
  output outcome_t                   cls_code,
  output logic [3*COORD_WIDTH+5:0]   cls_dmag,
  output logic signed [3*COORD_WIDTH+5:0] cls_tn
);

  localparam int W   = COORD_WIDTH;
  localparam int E   = W + 1;
  localparam int CP  = 2 * E + 1;
  localparam int SPL = W + 2;
  localparam int HW  = CP - SPL;
  localparam int LW  = SPL + 1;
  localparam int PH  = E + HW;
  localparam int PL  = E + LW;
  localparam int SH  = PH + 2;
  localparam int SL  = PL + 2;
  localparam int DW  = E + CP + 2;
  localparam int NST = 8;
  localparam int NX [3] = '{1, 2, 0};
  localparam int NY [3] = '{2, 0, 1};

  logic             front_en;
  logic [NST-1:0]   vld_r;

  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dir [3];
  logic signed [W-1:0] va  [3];
  logic signed [W-1:0] vb  [3];
  logic signed [W-1:0] vc  [3];

  logic signed [E-1:0]   dir1_r [3], e1_1_r [3], e2_1_r [3], tv1_r [3];
  logic signed [E-1:0]   dir2_r [3], e1_2_r [3], e2_2_r [3], tv2_r [3];
  logic signed [2*E-1:0] pa2_r [3], pb2_r [3], qa2_r [3], qb2_r [3];
  logic signed [E-1:0]   dir3_r [3], e1_3_r [3], e2_3_r [3], tv3_r [3];
  logic signed [CP-1:0]  pv3_r [3], qv3_r [3];

  logic signed [E-1:0]   xs [4][3];
  logic signed [CP-1:0]  ys [4][3];
  logic signed [PH-1:0]  ph4_r [4][3];
  logic signed [PL-1:0]  pl4_r [4][3];
  logic signed [SH-1:0]  sh5_r [4];
  logic signed [SL-1:0]  sl5_r [4];
  logic signed [DW-1:0]  dot6_r [4];

  logic signed [DW-1:0]  dmag7_r, un7_r, vn7_r, tn7_r;
  logic signed [DW:0]    uv_sum;
  logic                  par, ufail, vfail;

  outcome_t              code8_r;
  logic [DW-1:0]         dmag8_r;
  logic signed [DW-1:0]  tn8_r;

  // freeze the whole front when the oldest item cannot enter the queue
  assign front_en = !(vld_r[NST-1] && q_full);
  assign in_stall = !front_en;
  assign push     = vld_r[NST-1] && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (front_en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      org[k] = in_ray_origin[k*W +: W];
      dir[k] = in_ray_direction[k*W +: W];
      va[k]  = in_vertex_a[k*W +: W];
      vb[k]  = in_vertex_b[k*W +: W];
      vc[k]  = in_vertex_c[k*W +: W];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xs[0][k] = e1_3_r[k];
      xs[1][k] = tv3_r[k];
      xs[2][k] = dir3_r[k];
      xs[3][k] = e2_3_r[k];
      ys[0][k] = pv3_r[k];
      ys[1][k] = pv3_r[k];
      ys[2][k] = qv3_r[k];
      ys[3][k] = qv3_r[k];
    end
  end

  always_comb begin
    uv_sum = (DW+1)'(un7_r) + (DW+1)'(vn7_r);
    par    = (dmag7_r == '0) ||
             ($unsigned(dmag7_r) < {{(DW-EPS_W){1'b0}}, det_eps});
    ufail  = un7_r[DW-1] || (un7_r > dmag7_r);
    vfail  = vn7_r[DW-1] || (uv_sum > (DW+1)'(dmag7_r));
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      for (int k = 0; k < 3; k++) begin
        dir1_r[k] <= {dir[k][W-1], dir[k]};
        e1_1_r[k] <= {vb[k][W-1], vb[k]} - {va[k][W-1], va[k]};
        e2_1_r[k] <= {vc[k][W-1], vc[k]} - {va[k][W-1], va[k]};
        tv1_r[k]  <= {org[k][W-1], org[k]} - {va[k][W-1], va[k]};

        pa2_r[k]  <= dir1_r[NX[k]] * e2_1_r[NY[k]];
        pb2_r[k]  <= dir1_r[NY[k]] * e2_1_r[NX[k]];
        qa2_r[k]  <= tv1_r[NX[k]] * e1_1_r[NY[k]];
        qb2_r[k]  <= tv1_r[NY[k]] * e1_1_r[NX[k]];
        dir2_r[k] <= dir1_r[k];
        e1_2_r[k] <= e1_1_r[k];
        e2_2_r[k] <= e2_1_r[k];
        tv2_r[k]  <= tv1_r[k];

        pv3_r[k]  <= CP'(pa2_r[k]) - CP'(pb2_r[k]);
        qv3_r[k]  <= CP'(qa2_r[k]) - CP'(qb2_r[k]);
        dir3_r[k] <= dir2_r[k];
        e1_3_r[k] <= e1_2_r[k];
        e2_3_r[k] <= e2_2_r[k];
        tv3_r[k]  <= tv2_r[k];
      end

      // split each wide operand into a signed high and unsigned low half
      for (int d = 0; d < 4; d++) begin
        for (int k = 0; k < 3; k++) begin
          ph4_r[d][k] <= xs[d][k] * $signed(ys[d][k][CP-1:SPL]);
          pl4_r[d][k] <= xs[d][k] * $signed({1'b0, ys[d][k][SPL-1:0]});
        end
        sh5_r[d]  <= SH'(ph4_r[d][0]) + SH'(ph4_r[d][1]) + SH'(ph4_r[d][2]);
        sl5_r[d]  <= SL'(pl4_r[d][0]) + SL'(pl4_r[d][1]) + SL'(pl4_r[d][2]);
        dot6_r[d] <= (DW'(sh5_r[d]) <<< SPL) + DW'(sl5_r[d]);
      end

      // fold the determinant sign into the numerators
      dmag7_r <= dot6_r[0][DW-1] ? -dot6_r[0] : dot6_r[0];
      un7_r   <= dot6_r[0][DW-1] ? -dot6_r[1] : dot6_r[1];
      vn7_r   <= dot6_r[0][DW-1] ? -dot6_r[2] : dot6_r[2];
      tn7_r   <= dot6_r[0][DW-1] ? -dot6_r[3] : dot6_r[3];

      if (par) begin
        code8_r <= OUT_PARALLEL;
      end else if (ufail) begin
        code8_r <= OUT_U_RANGE;
      end else if (vfail) begin
        code8_r <= OUT_V_RANGE;
      end else begin
        code8_r <= OUT_HIT;
      end
      dmag8_r <= $unsigned(dmag7_r);
      tn8_r   <= tn7_r;
    end
  end

  assign cls_code = code8_r;
  assign cls_dmag = dmag8_r;
  assign cls_tn   = tn8_r;

endmodule

`default_nettype wire

@@ hdl/rti_queue.sv @@
// Short FIFO between the classifying front end and the dividing back end.
// Depends on rti_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rti_queue import rti_pkg::*; #(
  parameter int WIDTH = 141,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output q_stat_t               stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  `RTI_ASSERT(a_no_push_full, clk, rst_n, !(push && stat.full), "transfer into full queue")
  `RTI_ASSERT_NEXT(a_fills, clk, rst_n, push && !pop && cnt_r == CW'(DEPTH - 1), stat.full, "queue count lost an entry")

endmodule

`default_nettype wire

@@ hdl/rti_back.sv @@
// Back end: one-bit-per-stage divider for the distance, saturation and result register.
// Depends on rti_pkg and assert_macros.svh; drains rti_queue.
`default_nettype none
`include "assert_macros.svh"

module rti_back import rti_pkg::*; #(
  parameter int DOT_W = 69
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  output logic                   pop,
  input  wire outcome_t          in_code,
  input  wire logic [DOT_W-1:0]  in_dmag,
  input  wire logic signed [DOT_W-1:0] in_tn,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_hit,
  output logic signed [DIST_W-1:0] out_distance,
  output outcome_t               out_outcome
);

  localparam int DW = DOT_W;
  localparam int NW = DW + DIST_FRAC;
  localparam int BW = DW + QUOT_W;
  // stage 0 checks overflow, stages 1..QUOT_W each settle one quotient bit
  localparam int NS = QUOT_W + 1;
  localparam logic [QUOT_W-1:0] POS_LIM = QUOT_W'((64'd1 << (DIST_W - 1)) - 1);
  localparam logic [QUOT_W:0]   NEG_LIM = (QUOT_W+1)'(64'd1 << (DIST_W - 1));

  logic                back_en;
  logic [DW-1:0]       mag;
  logic                vld_r  [NS+1];
  outcome_t            code_r [NS+1];
  logic                neg_r  [NS+1];
  logic                ovf_r  [NS+1];
  logic [DW-1:0]       dmag_r [NS+1];
  logic [NW-1:0]       rem_r  [NS+1];
  logic [QUOT_W-1:0]   q_r    [NS+1];
  logic [BW-1:0]       trial  [NS];
  logic                ge     [NS];

  logic [QUOT_W:0]     qq;
  logic                pos_sat, neg_sat;
  logic                out_valid_r, out_hit_r;
  logic [DIST_W-1:0]   dist_r;
  outcome_t            outcome_r;

  assign back_en = !(out_valid_r && out_stall);
  assign pop     = back_en && in_vld;
  assign mag     = in_tn[DW-1] ? -in_tn : in_tn;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      trial[k] = {{(BW-DW){1'b0}}, dmag_r[k]} << (QUOT_W - k);
      ge[k]    = ({{(BW-NW){1'b0}}, rem_r[k]} >= trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NS; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (back_en) begin
      vld_r[0] <= in_vld;
      for (int k = 0; k < NS; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
      out_valid_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      code_r[0] <= in_code;
      neg_r[0]  <= in_tn[DW-1];
      ovf_r[0]  <= 1'b0;
      dmag_r[0] <= in_dmag;
      rem_r[0]  <= NW'(mag) << DIST_FRAC;
      q_r[0]    <= '0;
      for (int k = 0; k < NS; k++) begin
        code_r[k+1] <= code_r[k];
        neg_r[k+1]  <= neg_r[k];
        dmag_r[k+1] <= dmag_r[k];
        if (k == 0) begin
          ovf_r[k+1] <= ge[k];
          rem_r[k+1] <= rem_r[k];
          q_r[k+1]   <= q_r[k];
        end else begin
          ovf_r[k+1] <= ovf_r[k];
          if (ge[k]) begin
            rem_r[k+1] <= rem_r[k] - NW'(trial[k]);
            q_r[k+1]   <= q_r[k] | (QUOT_W'(1) << (QUOT_W - k));
          end else begin
            rem_r[k+1] <= rem_r[k];
            q_r[k+1]   <= q_r[k];
          end
        end
      end
    end
  end

  // negative side rounds toward minus infinity: bump magnitude on a remainder
  always_comb begin
    qq      = {1'b0, q_r[NS]} + (QUOT_W+1)'(rem_r[NS] != '0);
    pos_sat = ovf_r[NS] || (q_r[NS] > POS_LIM);
    neg_sat = ovf_r[NS] || (qq > NEG_LIM);
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      if (code_r[NS] != OUT_HIT) begin
        out_hit_r <= 1'b0;
        dist_r    <= '0;
        outcome_r <= code_r[NS];
      end else if (!neg_r[NS]) begin
        out_hit_r <= 1'b1;
        dist_r    <= pos_sat ? POS_LIM[DIST_W-1:0] : q_r[NS][DIST_W-1:0];
        outcome_r <= OUT_HIT;
      end else begin
        out_hit_r <= 1'b0;
        dist_r    <= neg_sat ? NEG_LIM[DIST_W-1:0] : -qq[DIST_W-1:0];
        outcome_r <= OUT_BEHIND;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = dist_r;
  assign out_outcome  = outcome_r;

  `RTI_ASSERT(a_reject_zero, clk, rst_n, !(out_valid && (out_outcome == OUT_PARALLEL || out_outcome == OUT_U_RANGE || out_outcome == OUT_V_RANGE)) || (out_distance == '0 && !out_hit), "early reject with distance or hit")
  `RTI_ASSERT(a_hit_sign, clk, rst_n, !(out_valid && out_hit) || !out_distance[DIST_W-1], "hit with negative distance")

endmodule

`default_nettype wire

@@ hdl/ray_triangle_intersect.sv @@
// Ray/triangle intersection (Moller-Trumbore) in exact fixed point. One ray and one
// triangle enter per transfer and one result leaves per item, in order; the block takes
// a new item every cycle while in_stall is low. Each item passes 8 front stages (edges,
// crosses, determinant, range tests), the first of which loads at the accepting edge,
// then the queue, and 36 back stages (input, overflow check, 33 divider stages that
// each settle one quotient bit, and the result register). A stall on the result channel
// freezes the back end; the queue then fills and stalls the input.
// The determinant threshold sits at byte address 0 of the configuration port; the user
// must write it only while the block is idle; the block itself does not enforce this.
`default_nettype none

module ray_triangle_intersect import rti_pkg::*; #(
  parameter int COORD_WIDTH = 21
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [APB_AW-1:0]    cfg_paddr,
  input  wire logic [APB_DW-1:0]    cfg_pwdata,
  output logic [APB_DW-1:0]         cfg_prdata,
  output logic                      cfg_pready,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [VEC_W-1:0]     in_ray_origin,
  input  wire logic [VEC_W-1:0]     in_ray_direction,
  input  wire logic [VEC_W-1:0]     in_vertex_a,
  input  wire logic [VEC_W-1:0]     in_vertex_b,
  input  wire logic [VEC_W-1:0]     in_vertex_c,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_hit,
  output logic signed [DIST_W-1:0]  out_distance,
  output logic [2:0]                out_outcome
);

  localparam int DOT_W = 3 * COORD_WIDTH + 6;
  localparam int QW    = 3 + 2 * DOT_W;

  logic [EPS_W-1:0]       eps_r;
  logic                   cfg_wr;
  reg_idx_t               cfg_idx;

  logic                   push;
  outcome_t               cls_code;
  logic [DOT_W-1:0]       cls_dmag;
  logic signed [DOT_W-1:0] cls_tn;
  q_stat_t                qstat;
  logic [QW-1:0]          q_dout;
  logic                   pop;
  outcome_t               bk_outcome;

  assign cfg_idx    = cfg_paddr[APB_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_idx == REG_DET_EPS);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_idx == REG_DET_EPS) ? {{(APB_DW-EPS_W){1'b0}}, eps_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_W'(EPS_RESET);
    end else if (cfg_wr) begin
      eps_r <= cfg_pwdata[EPS_W-1:0];
    end
  end

  rti_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ray_origin    (in_ray_origin),
    .in_ray_direction (in_ray_direction),
    .in_vertex_a      (in_vertex_a),
    .in_vertex_b      (in_vertex_b),
    .in_vertex_c      (in_vertex_c),
    .det_eps          (eps_r),
    .q_full           (qstat.full),
    .push             (push),
    .cls_code         (cls_code),
    .cls_dmag         (cls_dmag),
    .cls_tn           (cls_tn)
  );

  rti_queue #(
    .WIDTH(QW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   ({cls_code, cls_dmag, cls_tn}),
    .pop   (pop),
    .dout  (q_dout),
    .stat  (qstat)
  );

  rti_back #(
    .DOT_W(DOT_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (!qstat.empty),
    .pop          (pop),
    .in_code      (q_dout[QW-1 -: 3]),
    .in_dmag      (q_dout[2*DOT_W-1 -: DOT_W]),
    .in_tn        ($signed(q_dout[DOT_W-1:0])),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hit      (out_hit),
    .out_distance (out_distance),
    .out_outcome  (bk_outcome)
  );

  assign out_outcome = bk_outcome;

endmodule

`default_nettype wire
